@@ rtl/ermsd_pkg.sv @@
// Shared types and constants for the eRMSD pair G-vector deviation block.
// No dependencies; the other files, apart from ermsd_if and ermsd_div, refer to it by scoped names.
package ermsd_pkg;

  localparam int VEC_W        = 16;  // Q3.12 input components
  localparam int CUT_W        = 15;  // unsigned Q3.12 cutoff
  localparam int SQ_W         = 32;  // sum of three squares
  localparam int E_W          = 16;  // floor length
  localparam int ANG_W        = 16;  // phase, pi/65536 units
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 27;  // CORDIC datapath, Q24 signed
  localparam int ZW           = 18;  // CORDIC residual angle
  localparam int AMP_W        = 27;  // c*sin/e quotient
  localparam int T_W          = 29;  // c*(1+cos) >> 12
  localparam int OUT_W        = 32;

  localparam logic [CUT_W-1:0]    CUT_RESET = 15'd9830;
  localparam logic signed [CW-1:0] K24      = 27'sd10188014;
  localparam logic [28:0]          INV_PI   = 29'd341782638;
  localparam logic [ANG_W-1:0]     QUARTER  = 16'd32768;

  localparam logic [14:0] ATAN_TAB [CORDIC_STEPS] = '{
    15'd16384, 15'd9672, 15'd5110, 15'd2594, 15'd1302, 15'd652, 15'd326, 15'd163,
    15'd81, 15'd41, 15'd20, 15'd10, 15'd5, 15'd3, 15'd1, 15'd1
  };

  typedef logic [CUT_W-1:0] cut_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic signed [VEC_W-1:0] ref_gx;
    logic signed [VEC_W-1:0] ref_gy;
    logic signed [VEC_W-1:0] ref_gz;
    logic signed [VEC_W-1:0] ref_gw;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] sq_deviation;
    logic             within_cutoff;
  } out_t;

endpackage

@@ rtl/ermsd_if.sv @@
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; types come from ermsd_pkg.
interface ermsd_if #(parameter type PAYLOAD_T = logic);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ermsd_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on ermsd_pkg for widths.
module ermsd_isqrt #(
  parameter int SB_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ermsd_pkg::SQ_W-1:0] sq,
  input  logic [SB_W-1:0]            in_side,
  output logic                       out_valid,
  output logic [ermsd_pkg::E_W-1:0]  root,
  output logic [SB_W-1:0]            out_side
);
  localparam int N  = ermsd_pkg::E_W;
  localparam int RW = N + 2;

  logic                       vld [0:N];
  logic [RW-1:0]              rem [0:N];
  logic [N-1:0]               q   [0:N];
  logic [ermsd_pkg::SQ_W-1:0] s   [0:N];
  logic [SB_W-1:0]            sb  [0:N];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign s[0]   = sq;
  assign sb[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW+1:0] pre;
    logic [RW+1:0] trial;
    logic          ge;
    assign pre   = {rem[i], s[i][ermsd_pkg::SQ_W-1 -: 2]};
    assign trial = {2'b00, q[i], 2'b01};
    assign ge    = pre >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? RW'(pre - trial) : RW'(pre);
        q[i+1]   <= {q[i][N-2:0], ge};
        s[i+1]   <= s[i] << 2;
        sb[i+1]  <= sb[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = q[N];
  assign out_side  = sb[N];
endmodule

@@ rtl/ermsd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// The numerator bits above Q_W must be below the divisor; no package use.
module ermsd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int Q_W   = 16,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot,
  output logic [SB_W-1:0]  out_side
);
  logic             vld [0:Q_W];
  logic [DEN_W-1:0] rem [0:Q_W];
  logic [Q_W-1:0]   qn  [0:Q_W];
  logic [DEN_W-1:0] dv  [0:Q_W];
  logic [SB_W-1:0]  sb  [0:Q_W];

  assign vld[0] = in_valid;
  assign rem[0] = DEN_W'(num >> Q_W);
  assign qn[0]  = num[Q_W-1:0];
  assign dv[0]  = den;
  assign sb[0]  = in_side;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W:0] pre;
    logic           ge;
    assign pre = {rem[i], qn[i][Q_W-1]};
    assign ge  = pre >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? DEN_W'(pre - {1'b0, dv[i]}) : DEN_W'(pre);
        qn[i+1]  <= {qn[i][Q_W-2:0], ge};
        dv[i+1]  <= dv[i];
        sb[i+1]  <= sb[i];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = qn[Q_W];
  assign out_side  = sb[Q_W];
endmodule

@@ rtl/ermsd_cordic.sv @@
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, Q24 cos and sin.
// Depends on ermsd_pkg for the gain, the arctangent table and widths.
module ermsd_cordic #(
  parameter int SB_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ermsd_pkg::ANG_W-1:0]       angle,
  input  logic [SB_W-1:0]                   in_side,
  output logic                              out_valid,
  output logic signed [ermsd_pkg::CW-1:0]   cs,
  output logic signed [ermsd_pkg::CW-1:0]   sn,
  output logic [SB_W-1:0]                   out_side
);
  localparam int N  = ermsd_pkg::CORDIC_STEPS;
  localparam int CW = ermsd_pkg::CW;
  localparam int ZW = ermsd_pkg::ZW;

  logic                 vld [0:N];
  logic signed [CW-1:0] x   [0:N];
  logic signed [CW-1:0] y   [0:N];
  logic signed [ZW-1:0] z   [0:N];
  logic [SB_W-1:0]      sb  [0:N];

  assign vld[0] = in_valid;
  assign x[0]   = ermsd_pkg::K24;
  assign y[0]   = '0;
  assign z[0]   = $signed(ZW'(angle));
  assign sb[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;
    logic                 up;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    assign at = $signed(ZW'(ermsd_pkg::ATAN_TAB[i]));
    assign up = !z[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]  <= up ? x[i] - ys : x[i] + ys;
        y[i+1]  <= up ? y[i] + xs : y[i] - xs;
        z[i+1]  <= up ? z[i] - at : z[i] + at;
        sb[i+1] <= sb[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign cs        = x[N];
  assign sn        = y[N];
  assign out_side  = sb[N];
endmodule

@@ rtl/ermsd_pair_sq_deviation.sv @@
// eRMSD pair G-vector deviation: top level with the length, phase, CORDIC and
// amplitude pipelines. Depends on ermsd_pkg, ermsd_if, ermsd_isqrt, ermsd_div, ermsd_cordic.
//
// Usage
//   in  : one beat per nucleotide pair, the scaled pair vector (vec_x/y/z) and the
//         reference G-vector (ref_gx/gy/gz/gw), all signed Q3.12.
//   out : one beat per input beat, in order: sq_deviation (unsigned Q8.24,
//         saturating at all ones) and within_cutoff.
//   cfg : writes the cutoff radius (unsigned Q3.12). ready is always high; write
//         only while no beat is in flight.
// Depth: set by the bit-serial stages: 16 square-root stages, 16 phase-divider
//   stages, 16 CORDIC stages, 27 amplitude-divider stages, plus 9
//   square/sum/product/difference/output register stages.
// Throughput: one beat per cycle, sustained while out is not stalled.
// Reset: rst (synchronous) empties the pipeline and loads the cutoff with 9830.
// Stall: when out holds a beat that is not taken, the whole pipeline holds and
//   in.ready drops; nothing is lost or repeated. in.ready stays high while the
//   output register is empty or being drained; bubbles travel with the beats.
module ermsd_pair_sq_deviation (
  input  logic   clk,
  input  logic   rst,
  ermsd_if.sink   in,
  ermsd_if.source out,
  ermsd_if.sink   cfg
);
  localparam int VEC_W = ermsd_pkg::VEC_W;
  localparam int CUT_W = ermsd_pkg::CUT_W;
  localparam int E_W   = ermsd_pkg::E_W;
  localparam int CW    = ermsd_pkg::CW;
  localparam int AMP_W = ermsd_pkg::AMP_W;
  localparam int T_W   = ermsd_pkg::T_W;
  localparam int NUM2_W = CUT_W + 25;
  localparam int GK_W   = VEC_W + AMP_W;  // signed v times amplitude
  localparam int D_W    = 32;

  typedef struct packed {
    ermsd_pkg::in_t    p;
    logic              act;     // within cutoff and nonzero length
    logic              in_cut;
    logic [E_W-1:0]    e;
  } side_b_t;

  typedef struct packed {
    side_b_t b;
    logic    neg;
  } side_c_t;

  typedef struct packed {
    side_b_t        b;
    logic [T_W-1:0] t;
  } side_d_t;

  localparam int SB_A = $bits(ermsd_pkg::in_t);
  localparam int SB_B = $bits(side_b_t);
  localparam int SB_C = $bits(side_c_t);
  localparam int SB_D = $bits(side_d_t);

  logic adv;
  ermsd_pkg::cut_t cutoff;

  // Advance everything whenever the output register is free or being emptied.
  assign adv       = !out.valid || out.ready;
  assign in.ready  = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= ermsd_pkg::CUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      cutoff <= cfg.data;
    end
  end

  // Squares of the vector components.
  logic           s0_valid;
  ermsd_pkg::in_t s0_p;
  logic [30:0]    s0_xx, s0_yy, s0_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p  <= in.data;
      s0_xx <= 31'(in.data.vec_x * in.data.vec_x);
      s0_yy <= 31'(in.data.vec_y * in.data.vec_y);
      s0_zz <= 31'(in.data.vec_z * in.data.vec_z);
    end
  end

  // Sum of squares; at most 3 * 2^30, fits 32 bits.
  logic                       s1_valid;
  ermsd_pkg::in_t             s1_p;
  logic [ermsd_pkg::SQ_W-1:0] s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p   <= s0_p;
      s1_sum <= 32'(s0_xx) + 32'(s0_yy) + 32'(s0_zz);
    end
  end

  // Floor length.
  logic           e_valid;
  logic [E_W-1:0] e_root;
  logic [SB_A-1:0] e_side;

  ermsd_isqrt #(.SB_W(SB_A)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s1_valid),
    .sq       (s1_sum),
    .in_side  (s1_p),
    .out_valid(e_valid),
    .root     (e_root),
    .out_side (e_side)
  );

  // Phase a = e * 65536 / c. Below the cutoff e < c, so the quotient fits 16 bits;
  // elsewhere the quotient is don't-care because act masks the G-vector.
  side_b_t ph_in;
  always_comb begin
    ph_in.p      = ermsd_pkg::in_t'(e_side);
    ph_in.in_cut = e_root < {1'b0, cutoff};
    ph_in.act    = ph_in.in_cut && (e_root != '0);
    ph_in.e      = e_root;
  end

  logic              a_valid;
  logic [E_W-1:0]    a_quot;
  logic [SB_B-1:0]   a_side;

  ermsd_div #(.NUM_W(2 * E_W), .DEN_W(E_W), .Q_W(ermsd_pkg::ANG_W), .SB_W(SB_B)) u_phase_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (e_valid),
    .num      ({e_root, 16'h0000}),
    .den      ({1'b0, cutoff}),
    .in_side  (ph_in),
    .out_valid(a_valid),
    .quot     (a_quot),
    .out_side (a_side)
  );

  // Fold the second quadrant onto the first; negate the cosine later.
  side_c_t                     cd_in;
  logic [ermsd_pkg::ANG_W-1:0] cd_ang;
  always_comb begin
    cd_in.b   = side_b_t'(a_side);
    cd_in.neg = a_quot > ermsd_pkg::QUARTER;
    cd_ang    = cd_in.neg ? ermsd_pkg::ANG_W'(17'h10000 - {1'b0, a_quot}) : a_quot;
  end

  logic                 c_valid;
  logic signed [CW-1:0] c_cs, c_sn;
  logic [SB_C-1:0]      c_side;

  ermsd_cordic #(.SB_W(SB_C)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (a_valid),
    .angle    (cd_ang),
    .in_side  (cd_in),
    .out_valid(c_valid),
    .cs       (c_cs),
    .sn       (c_sn),
    .out_side (c_side)
  );

  // Clamp sine and 1+cos at zero, scale both by the cutoff.
  side_c_t              c_sd;
  logic signed [CW-1:0] cs_f;
  logic signed [CW:0]   onepc;
  logic [24:0]          sn_c;
  logic [25:0]          onepc_c;

  always_comb begin
    c_sd    = side_c_t'(c_side);
    cs_f    = c_sd.neg ? -c_cs : c_cs;
    sn_c    = c_sn[CW-1] ? '0 : 25'(c_sn);
    onepc   = (CW+1)'(32'sd16777216) + (CW+1)'(cs_f);
    onepc_c = onepc[CW] ? '0 : 26'(onepc);
  end

  logic              p1_valid;
  side_d_t           p1_sd;
  logic [NUM2_W-1:0] p1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_sd.b <= c_sd.b;
      p1_sd.t <= T_W'(({26'b0, cutoff} * {15'b0, onepc_c}) >> 12);
      p1_num  <= NUM2_W'({25'b0, cutoff} * {15'b0, sn_c});
    end
  end

  // Amplitude c * sin / e; stays below 2^27 for any nonzero e below the cutoff.
  logic              d_valid;
  logic [AMP_W-1:0]  d_amp;
  logic [SB_D-1:0]   d_side;

  ermsd_div #(.NUM_W(NUM2_W), .DEN_W(E_W), .Q_W(AMP_W), .SB_W(SB_D)) u_amp_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (p1_valid),
    .num      (p1_num),
    .den      (p1_sd.b.e),
    .in_side  (p1_sd),
    .out_valid(d_valid),
    .quot     (d_amp),
    .out_side (d_side)
  );

  // Multiply by 1/pi.
  side_d_t     d_sd;
  logic        q1_valid;
  side_b_t     q1_b;
  logic [55:0] q1_amp_prod;
  logic [57:0] q1_w_prod;

  assign d_sd = side_d_t'(d_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else if (adv) begin
      q1_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_b        <= d_sd.b;
      q1_amp_prod <= 56'({29'b0, d_amp} * {27'b0, ermsd_pkg::INV_PI});
      q1_w_prod   <= 58'({29'b0, d_sd.t} * {29'b0, ermsd_pkg::INV_PI});
    end
  end

  // G_k before the final shift: v_k * amp2.
  logic [25:0]            amp2;
  logic                   q2_valid;
  side_b_t                q2_b;
  logic signed [GK_W-1:0] q2_gx, q2_gy, q2_gz;
  logic [27:0]            q2_gw;

  assign amp2 = 26'(q1_amp_prod >> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_valid <= 1'b0;
    end else if (adv) begin
      q2_valid <= q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_b  <= q1_b;
      q2_gx <= GK_W'(q1_b.p.vec_x * $signed({1'b0, amp2}));
      q2_gy <= GK_W'(q1_b.p.vec_y * $signed({1'b0, amp2}));
      q2_gz <= GK_W'(q1_b.p.vec_z * $signed({1'b0, amp2}));
      q2_gw <= 28'(q1_w_prod >> 30);
    end
  end

  // Differences from the reference in Q24; G is zero outside the active range.
  logic signed [GK_W-13:0] gx, gy, gz;
  logic signed [D_W-1:0]   gx_m, gy_m, gz_m, gw_m;

  always_comb begin
    gx   = (GK_W-12)'(q2_gx >>> 12);
    gy   = (GK_W-12)'(q2_gy >>> 12);
    gz   = (GK_W-12)'(q2_gz >>> 12);
    gx_m = q2_b.act ? D_W'(gx) : '0;
    gy_m = q2_b.act ? D_W'(gy) : '0;
    gz_m = q2_b.act ? D_W'(gz) : '0;
    gw_m = q2_b.act ? $signed(D_W'(q2_gw)) : '0;
  end

  logic                  q3_valid;
  logic                  q3_within;
  logic signed [D_W-1:0] q3_d [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      q3_valid <= 1'b0;
    end else if (adv) begin
      q3_valid <= q2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q3_within <= q2_b.in_cut;
      q3_d[0]   <= (D_W'(q2_b.p.ref_gx) <<< 12) - gx_m;
      q3_d[1]   <= (D_W'(q2_b.p.ref_gy) <<< 12) - gy_m;
      q3_d[2]   <= (D_W'(q2_b.p.ref_gz) <<< 12) - gz_m;
      q3_d[3]   <= (D_W'(q2_b.p.ref_gw) <<< 12) - gw_m;
    end
  end

  // Squares.
  logic        q4_valid;
  logic        q4_within;
  logic [61:0] q4_sq [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      q4_valid <= 1'b0;
    end else if (adv) begin
      q4_valid <= q3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_within <= q3_within;
      for (int k = 0; k < 4; k++) begin
        q4_sq[k] <= 62'(q3_d[k] * q3_d[k]);
      end
    end
  end

  // Pairwise sums.
  logic        q5_valid;
  logic        q5_within;
  logic [62:0] q5_s01, q5_s23;

  always_ff @(posedge clk) begin
    if (rst) begin
      q5_valid <= 1'b0;
    end else if (adv) begin
      q5_valid <= q4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_within <= q4_within;
      q5_s01    <= 63'(q4_sq[0]) + 63'(q4_sq[1]);
      q5_s23    <= 63'(q4_sq[2]) + 63'(q4_sq[3]);
    end
  end

  // Final sum, drop 24 fraction bits, saturate into the output register.
  logic [63:0] total;
  logic [39:0] total_sh;

  assign total    = 64'(q5_s01) + 64'(q5_s23);
  assign total_sh = 40'(total >> 24);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (adv) begin
      out.valid <= q5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out.data.within_cutoff <= q5_within;
      out.data.sq_deviation  <= (total_sh[39:32] != '0) ? '1 : total_sh[31:0];
    end
  end

  // A stalled output freezes the deep stages.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(c_valid) && $stable(d_valid) && $stable(e_valid))
    else $error("pipeline moved during an output stall");

  // The output register only fills from the last stage.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(out.valid) |-> $past(q5_valid) && $past(adv))
    else $error("output beat without a source stage");

  // Outside the cutoff the G-vector is zero, so the final differences are the reference.
  a_zero_g: assert property (@(posedge clk) disable iff (rst)
    q2_valid && !q2_b.in_cut |-> gx_m == '0 && gy_m == '0 && gz_m == '0 && gw_m == '0)
    else $error("G-vector not cleared outside the cutoff");
endmodule
